@@ rtl/llmf_pkg.sv @@
`default_nettype none

package llmf_pkg;

  localparam int CH_W     = 16;
  localparam int RADIUS_W = 8;
  localparam int SUM_W    = 18;
  localparam int PROD_W   = 36;

  // floor(s / 3) == (s * DIV3_MUL) >> DIV3_SHIFT for every s below 2**19
  localparam logic [SUM_W-1:0] DIV3_MUL   = 18'd174763;
  localparam int               DIV3_SHIFT = 19;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
    logic            last_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] alpha_out;
    logic            last_out;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] luma;
    pix_t            pix;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_DIV,
    ST_LOAD_WR,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic load_capture;
    logic load_div;
    logic load_write;
    logic emit_setup;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/llmf_ctrl.sv @@
`default_nettype none

module llmf_ctrl
  import llmf_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  output logic    in_ready,
  input  wire     in_opcode,
  output logic    out_valid,
  input  wire     out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_capture = 1'b1;
            state_nxt        = ST_LOAD_DIV;
          end else if (st.emit_ok) begin
            cmd.emit_setup = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_LOAD_DIV: begin
        cmd.load_div = 1'b1;
        state_nxt    = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd.load_write = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        // hold until the previous beat has left the output register
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/llmf_dp.sv @@
`default_nettype none

module llmf_dp
  import llmf_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  in_t                  in_data,
  input  wire                  cfg_we,
  input  wire [RADIUS_W-1:0]   cfg_data,
  input  cmd_t                 cmd,
  output status_t              st,
  output out_t                 out_data
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int SW = ((LW > RADIUS_W) ? LW : RADIUS_W) + 1;

  entry_t mem [MAX_LINE];
  entry_t rdata_r;

  logic [RADIUS_W-1:0] radius_r;
  logic [LW-1:0]       len_r;
  logic [CH_W-1:0]     peak_r;
  logic [LW-1:0]       pos_r;
  logic                closed_r;

  pix_t            pix_r;
  logic [SUM_W-1:0] sum_r;
  logic            last_r;
  logic [CH_W-1:0] luma_r;

  logic [LW-1:0]   k_r;
  logic [LW-1:0]   hi_r;
  logic            pass_r;
  logic            found_r;
  logic            rvalid_r;
  logic [CH_W-1:0] best_r;
  pix_t            chosen_r;
  out_t            out_r;

  logic [PROD_W-1:0] prod;
  logic              mem_we;
  logic              issue;
  logic [SW-1:0]     pos_w;
  logic [SW-1:0]     rad_w;
  logic [SW-1:0]     hi_w;
  logic [SW-1:0]     end_w;
  logic [SW-1:0]     lo_w;
  logic              pass_now;

  assign prod   = PROD_W'(sum_r) * PROD_W'(DIV3_MUL);
  assign mem_we = cmd.load_write && (len_r < LW'(MAX_LINE));
  assign issue  = cmd.scan && (k_r <= hi_r) && !found_r;

  assign pos_w    = SW'(pos_r);
  assign rad_w    = SW'(radius_r);
  assign hi_w     = pos_w + rad_w;
  assign end_w    = SW'(len_r) - SW'(1);
  assign lo_w     = (pos_w >= rad_w) ? (pos_w - rad_w) : '0;
  assign pass_now = (radius_r == '0) || (peak_r == '0);

  assign st.emit_ok   = closed_r && (len_r != '0) && (pos_r < len_r);
  assign st.scan_done = found_r || ((k_r > hi_r) && !rvalid_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len_r[AW-1:0]] <= '{luma: luma_r, pix: pix_r};
    end
    if (issue) begin
      rdata_r <= mem[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      len_r    <= '0;
      peak_r   <= '0;
      pos_r    <= '0;
      closed_r <= 1'b0;
      rvalid_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_data;
      end
      // a load after a closed line starts a new one
      if (cmd.load_capture && closed_r) begin
        len_r    <= '0;
        peak_r   <= '0;
        pos_r    <= '0;
        closed_r <= 1'b0;
      end
      if (cmd.load_write) begin
        if (mem_we) begin
          len_r <= len_r + LW'(1);
          if (luma_r > peak_r) begin
            peak_r <= luma_r;
          end
        end
        if (last_r) begin
          closed_r <= 1'b1;
        end
      end
      if (cmd.emit_setup) begin
        rvalid_r <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        rvalid_r <= issue;
        if (rvalid_r && !pass_r && (rdata_r.luma >= peak_r)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        pos_r <= pos_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_capture) begin
      pix_r  <= '{alpha: in_data.alpha_in, blue: in_data.blue_in,
                  green: in_data.green_in, red: in_data.red_in};
      sum_r  <= SUM_W'(in_data.red_in) + SUM_W'(in_data.green_in)
              + SUM_W'(in_data.blue_in);
      last_r <= in_data.last_in;
    end
    if (cmd.load_div) begin
      luma_r <= prod[DIV3_SHIFT +: CH_W];
    end
    if (cmd.emit_setup) begin
      pass_r   <= pass_now;
      best_r   <= '0;
      chosen_r <= '0;
      if (pass_now) begin
        k_r  <= pos_r;
        hi_r <= pos_r;
      end else begin
        k_r  <= lo_w[LW-1:0];
        hi_r <= (hi_w > end_w) ? end_w[LW-1:0] : hi_w[LW-1:0];
      end
    end else begin
      if (issue) begin
        k_r <= k_r + LW'(1);
      end
      if (rvalid_r) begin
        if (pass_r) begin
          chosen_r <= rdata_r.pix;
        end else if (rdata_r.luma > best_r) begin
          best_r   <= rdata_r.luma;
          chosen_r <= rdata_r.pix;
        end
      end
    end
    if (cmd.out_load) begin
      out_r <= '{red_out:   chosen_r.red,
                 green_out: chosen_r.green,
                 blue_out:  chosen_r.blue,
                 alpha_out: chosen_r.alpha,
                 last_out:  (pos_r == (len_r - LW'(1)))};
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/line_luma_max_filter.sv @@
// Luminance-driven 1-D max filter over one line of 16-bit RGBA pixels.
// Input channel (in_valid/in_ready/in_data): a beat with opcode load appends
// a pixel to the line; last_in closes the line, and the next load starts a
// new one. A beat with opcode emit returns the pixel of greatest luminance
// within radius of the next position, on the output channel.
// Emits before the line is closed or past its end are taken and dropped.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the radius; it is
// always ready; the user must write it only while the block is idle, and
// the block does not enforce this. A load captures the pixel, derives its
// luminance and writes it to the line memory. An emit scans the line memory
// over the clipped window (at most 2*radius+1 pixels, or 1 for a zero radius
// or an all-zero line), one read per cycle, ending early at the line's peak.
// The output register holds one result; while the receiver stalls, the
// block still takes loads and dropped emits, and a new emit waits at the
// end of its scan. Reset clears the line, the output valid and sets the
// radius to 1; line memory contents are left as they are.
`default_nettype none

module line_luma_max_filter
  import llmf_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output out_t                out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [RADIUS_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  llmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  llmf_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/llmf_chk.sv @@
`default_nettype none

module llmf_chk
  import llmf_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input in_t                in_data,
  input wire                out_valid,
  input wire                out_ready,
  input out_t               out_data,
  input wire                cfg_valid,
  input wire                cfg_ready,
  input wire [RADIUS_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.opcode == OP_LOAD)) |=> !in_ready)
    else $error("input taken during a load");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a scan");

endmodule

bind line_luma_max_filter llmf_chk u_chk (.*);

`default_nettype wire

@@ test/tb_line_luma_max_filter.sv @@
`default_nettype none

module tb_line_luma_max_filter;
  import llmf_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int LINE_MAX       = 1024;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 5_000_000;
  localparam int RANDOM_BLOCK   = 70;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_CHECKED,
    ROW_RADIUS
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    in_t                   item;
    out_t                  want;
    logic [RADIUS_W-1:0]   radius;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RADIUS_W-1:0] cfg_data;

  line_luma_max_filter #(
    .MAX_LINE (LINE_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Line state mirrored from the block
  pix_t                line_pix [LINE_MAX];
  logic [CH_W-1:0]     line_luma [LINE_MAX];
  int                  line_len = 0;
  logic [CH_W-1:0]     line_peak = '0;
  int                  emit_pos = 0;
  bit                  line_closed = 1'b0;
  logic [RADIUS_W-1:0] cur_radius = RADIUS_RST;

  out_t      pending_pixels [$];
  out_t      oldest_want;
  stim_row_t stim_rows [$];
  int        fail_count = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        stall_left = 0;

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Apply one accepted beat to the mirrored line; report the pixel it yields, if any.
  task automatic luma_max_step(input in_t it, output bit produced, output out_t px_out);
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  luma;
    logic [CH_W-1:0]  best;
    pix_t             chosen;
    int               lo;
    int               hi;
    int               k;
    produced = 1'b0;
    px_out = '0;
    if (it.opcode == OP_LOAD) begin
      if (line_closed) begin
        line_len = 0;
        line_peak = '0;
        emit_pos = 0;
        line_closed = 1'b0;
      end
      if (line_len < LINE_MAX) begin
        sum = it.red_in + it.green_in + it.blue_in;
        luma = CH_W'(sum / 3);
        line_pix[line_len] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
        line_luma[line_len] = luma;
        if (luma > line_peak) begin
          line_peak = luma;
        end
        line_len++;
      end
      if (it.last_in) begin
        line_closed = 1'b1;
      end
    end else if (line_closed && line_len != 0 && emit_pos < line_len) begin
      if (cur_radius == 0 || line_peak == 0) begin
        chosen = line_pix[emit_pos];
      end else begin
        lo = (emit_pos >= cur_radius) ? emit_pos - cur_radius : 0;
        hi = emit_pos + cur_radius;
        if (hi > line_len - 1) begin
          hi = line_len - 1;
        end
        best = '0;
        chosen = '0;
        // stop once the line peak is reached: nothing later can beat it
        for (k = lo; k <= hi && best < line_peak; k++) begin
          if (line_luma[k] > best) begin
            best = line_luma[k];
            chosen = line_pix[k];
          end
        end
      end
      px_out.red_out = chosen.red;
      px_out.green_out = chosen.green;
      px_out.blue_out = chosen.blue;
      px_out.alpha_out = chosen.alpha;
      px_out.last_out = (emit_pos == line_len - 1);
      produced = 1'b1;
      emit_pos++;
    end
  endtask

  function automatic logic [CH_W-1:0] rand_channel(input int mode);
    case (mode)
      0: return CH_W'($urandom);
      1: return CH_W'($urandom_range(3));
      2: return ($urandom_range(5) == 0) ? CH_W'($urandom) : '0;
      default: return ($urandom_range(1) == 1) ? {CH_W{1'b1}} : '0;
    endcase
  endfunction

  function automatic in_t rand_load(input int mode, input bit last);
    in_t it;
    it.opcode = OP_LOAD;
    it.red_in = rand_channel(mode);
    it.green_in = rand_channel(mode);
    it.blue_in = rand_channel(mode);
    it.alpha_in = CH_W'($urandom);
    it.last_in = last;
    return it;
  endfunction

  function automatic in_t rand_emit();
    logic [95:0] bits;
    in_t         it;
    bits = {$urandom, $urandom, $urandom};
    it = bits[$bits(in_t)-1:0];
    it.opcode = OP_EMIT;
    return it;
  endfunction

  function automatic stim_row_t load_row(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                         input logic [CH_W-1:0] b, input logic [CH_W-1:0] a,
                                         input logic last);
    stim_row_t row;
    row = '0;
    row.kind = ROW_PREDICTED;
    row.item.opcode = OP_LOAD;
    row.item.red_in = r;
    row.item.green_in = g;
    row.item.blue_in = b;
    row.item.alpha_in = a;
    row.item.last_in = last;
    return row;
  endfunction

  function automatic stim_row_t emit_row();
    stim_row_t row;
    row = '0;
    row.kind = ROW_PREDICTED;
    row.item = rand_emit();
    return row;
  endfunction

  function automatic stim_row_t emit_row_want(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b,
                                              input logic [CH_W-1:0] a, input logic last);
    stim_row_t row;
    row = emit_row();
    row.kind = ROW_CHECKED;
    row.want.red_out = r;
    row.want.green_out = g;
    row.want.blue_out = b;
    row.want.alpha_out = a;
    row.want.last_out = last;
    return row;
  endfunction

  function automatic stim_row_t radius_row(input logic [RADIUS_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_RADIUS;
    row.radius = value;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input in_t it, input bit typed, input out_t typed_px);
    bit   produced;
    out_t px;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    luma_max_step(it, produced, px);
    if (produced) begin
      pending_pixels.push_back(typed ? typed_px : px);
    end
    @(negedge clk);
  endtask

  task automatic drain_results(input int extra);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    drain_results(SETTLE_CYCLES);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    cur_radius = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly whole lines followed by emits; some stray beats in between.
  task automatic run_random(input int n_items, input bit with_hold);
    int   count;
    int   lines;
    int   len;
    int   mode;
    int   n_emit;
    int   i;
    in_t  it;
    bit   held;
    count = 0;
    lines = 0;
    held = 1'b0;
    while (count < n_items) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 12);
        mode = $urandom_range(3);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(15) == 0) begin
            send_item(rand_emit(), 1'b0, '0);
            count++;
          end
          send_item(rand_load(mode, i == len - 1), 1'b0, '0);
        end
        n_emit = ($urandom_range(4) == 0) ? $urandom_range(len) : len + $urandom_range(2);
        if (with_hold && !held) begin
          hold_requests++;
          held = 1'b1;
        end
        for (i = 0; i < n_emit; i++) begin
          send_item(rand_emit(), 1'b0, '0);
        end
        count += len + n_emit;
        lines++;
        if (lines == 1 || $urandom_range(7) == 0) begin
          drain_results(0);
        end
      end else begin
        for (i = $urandom_range(1, 4); i > 0; i--) begin
          it = rand_emit();
          it.opcode = ($urandom_range(1) == 1) ? OP_EMIT : OP_LOAD;
          it.last_in = ($urandom_range(3) == 0);
          send_item(it, 1'b0, '0);
          count++;
        end
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result beat: %h", out_data));
      end else begin
        oldest_want = pending_pixels.pop_front();
        if (out_data.red_out !== oldest_want.red_out ||
            out_data.green_out !== oldest_want.green_out ||
            out_data.blue_out !== oldest_want.blue_out ||
            out_data.alpha_out !== oldest_want.alpha_out ||
            out_data.last_out !== oldest_want.last_out) begin
          flag_error($sformatf(
            "pixel mismatch: want r=%h g=%h b=%h a=%h last=%b, got r=%h g=%h b=%h a=%h last=%b",
            oldest_want.red_out, oldest_want.green_out, oldest_want.blue_out,
            oldest_want.alpha_out, oldest_want.last_out, out_data.red_out,
            out_data.green_out, out_data.blue_out, out_data.alpha_out, out_data.last_out));
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

  initial begin
    int                  i;
    int                  ph;
    int                  blk;
    logic [RADIUS_W-1:0] radius_plan [6];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // nothing loaded yet, then an emit on a line still open
    stim_rows.push_back(emit_row());
    stim_rows.push_back(load_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    stim_rows.push_back(emit_row());
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_rows.push_back(load_row(16'h0003, 16'h0003, 16'h0003, 16'h0007, 1'b1));
    stim_rows.push_back(emit_row_want(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    stim_rows.push_back(emit_row_want(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    stim_rows.push_back(emit_row_want(16'h0003, 16'h0003, 16'h0003, 16'h0007, 1'b1));
    stim_rows.push_back(emit_row());
    // luma of zero everywhere: pixels pass through
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b0));
    stim_rows.push_back(load_row(16'h0001, 16'h0001, 16'h0000, 16'hABCD, 1'b1));
    stim_rows.push_back(emit_row_want(16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b0));
    stim_rows.push_back(emit_row_want(16'h0001, 16'h0001, 16'h0000, 16'hABCD, 1'b1));
    // dark window inside a lit line, then zero and widest radius
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0000, 16'h0005, 1'b0));
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0000, 16'h0006, 1'b0));
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0000, 16'h0007, 1'b0));
    stim_rows.push_back(load_row(16'h0009, 16'h0009, 16'h0009, 16'h0009, 1'b1));
    stim_rows.push_back(emit_row_want(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_rows.push_back(radius_row(8'd0));
    stim_rows.push_back(emit_row_want(16'h0000, 16'h0000, 16'h0000, 16'h0006, 1'b0));
    stim_rows.push_back(radius_row(8'd255));
    stim_rows.push_back(emit_row_want(16'h0009, 16'h0009, 16'h0009, 16'h0009, 1'b0));
    stim_rows.push_back(emit_row_want(16'h0009, 16'h0009, 16'h0009, 16'h0009, 1'b1));
    // equal luma everywhere: the first pixel wins
    stim_rows.push_back(load_row(16'h0003, 16'h0000, 16'h0000, 16'h0001, 1'b0));
    stim_rows.push_back(load_row(16'h0000, 16'h0003, 16'h0000, 16'h0002, 1'b0));
    stim_rows.push_back(load_row(16'h0000, 16'h0000, 16'h0003, 16'h0003, 1'b1));
    stim_rows.push_back(emit_row_want(16'h0003, 16'h0000, 16'h0000, 16'h0001, 1'b0));
    stim_rows.push_back(emit_row());
    stim_rows.push_back(emit_row_want(16'h0003, 16'h0000, 16'h0000, 16'h0001, 1'b1));

    send_gap_pct = 19;
    recv_stall_pct = 80;
    for (i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_RADIUS) begin
        write_radius(stim_rows[i].radius);
      end else begin
        send_item(stim_rows[i].item, stim_rows[i].kind == ROW_CHECKED, stim_rows[i].want);
      end
    end

    radius_plan[0] = 8'd3;
    radius_plan[1] = 8'd0;
    radius_plan[2] = 8'd255;
    radius_plan[3] = RADIUS_W'($urandom_range(4, 40));
    radius_plan[4] = 8'd1;
    radius_plan[5] = 8'd2;
    for (ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 19 : (ph == 1) ? 80 : 0;
      recv_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 19 : 0;
      for (blk = 0; blk < 2; blk++) begin
        write_radius(radius_plan[ph * 2 + blk]);
        run_random(RANDOM_BLOCK, ph == 2 && blk == 0);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
